// ===== hw/rtl/pu_pkg.sv =====
// package: microcode word, datapath control and status types, factorial table
package pu_pkg;

  localparam int PC_W   = 3;
  localparam int N_W    = 4;
  localparam int RANK_W = 29;

  localparam logic [2:0] OP_IDLE = 3'd0;
  localparam logic [2:0] OP_INIT = 3'd1;
  localparam logic [2:0] OP_DIV  = 3'd2;
  localparam logic [2:0] OP_EMIT = 3'd3;
  localparam logic [2:0] OP_NEXT = 3'd4;
  localparam logic [2:0] OP_ERR  = 3'd5;

  localparam logic [2:0] C_ALWAYS = 3'd0;
  localparam logic [2:0] C_ACCEPT = 3'd1;
  localparam logic [2:0] C_BAD    = 3'd2;
  localparam logic [2:0] C_GE     = 3'd3;
  localparam logic [2:0] C_LAST   = 3'd4;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
    logic [PC_W-1:0] nxt;
  } cw_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ready;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic bad;
    logic ge;
    logic last;
    logic free;
  } stat_t;

  function automatic logic [RANK_W-1:0] fact_of(input logic [N_W-1:0] i);
    logic [RANK_W-1:0] f;
    case (i)
      4'd0:    f = 29'd1;
      4'd1:    f = 29'd1;
      4'd2:    f = 29'd2;
      4'd3:    f = 29'd6;
      4'd4:    f = 29'd24;
      4'd5:    f = 29'd120;
      4'd6:    f = 29'd720;
      4'd7:    f = 29'd5040;
      4'd8:    f = 29'd40320;
      4'd9:    f = 29'd362880;
      4'd10:   f = 29'd3628800;
      4'd11:   f = 29'd39916800;
      4'd12:   f = 29'd479001600;
      default: f = 29'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/pu_if.sv =====
// stream interfaces for the input and result channels
interface pu_in_if;
  logic                      valid;
  logic                      ready;
  logic [pu_pkg::N_W-1:0]    perm_length;
  logic [pu_pkg::RANK_W-1:0] rank;
  modport source (output valid, output perm_length, output rank, input ready);
  modport sink   (input valid, input perm_length, input rank, output ready);
  modport mon    (input valid, input perm_length, input rank, input ready);
endinterface

interface pu_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] element;
  logic       last;
  logic       error;
  modport source (output valid, output element, output last, output error, input ready);
  modport sink   (input valid, input element, input last, input error, output ready);
  modport mon    (input valid, input element, input last, input error, input ready);
endinterface

// ===== hw/rtl/pu_seq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
module pu_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  pu_pkg::stat_t stat,
  output pu_pkg::ctrl_t ctrl
);
  import pu_pkg::*;

  localparam int ROM_D = 2 ** PC_W;

  localparam cw_t ROM [ROM_D] = '{
    '{op: OP_IDLE, cond: C_ACCEPT, target: 3'd1, nxt: 3'd0},
    '{op: OP_INIT, cond: C_BAD,    target: 3'd5, nxt: 3'd2},
    '{op: OP_DIV,  cond: C_GE,     target: 3'd2, nxt: 3'd3},
    '{op: OP_EMIT, cond: C_LAST,   target: 3'd0, nxt: 3'd4},
    '{op: OP_NEXT, cond: C_ALWAYS, target: 3'd2, nxt: 3'd2},
    '{op: OP_ERR,  cond: C_ALWAYS, target: 3'd0, nxt: 3'd0},
    '{op: OP_IDLE, cond: C_ALWAYS, target: 3'd0, nxt: 3'd0},
    '{op: OP_IDLE, cond: C_ALWAYS, target: 3'd0, nxt: 3'd0}
  };

  logic [PC_W-1:0] pc_r, pc_nxt;
  cw_t             cw;
  logic            take;
  logic            stall;

  assign cw = ROM[pc_r];

  always_comb begin
    case (cw.cond)
      C_ACCEPT: take = stat.in_valid;
      C_BAD:    take = stat.bad;
      C_GE:     take = stat.ge;
      C_LAST:   take = stat.last;
      default:  take = 1'b1;
    endcase
  end

  assign stall = (cw.op == OP_EMIT || cw.op == OP_ERR) && !stat.free;

  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = cw.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op    = cw.op;
  assign ctrl.ready = (cw.op == OP_IDLE);

endmodule

// ===== hw/rtl/pu_dp.sv =====
// datapath: rank and factorial registers, used-value mask, result register
module pu_dp #(
  parameter int MAX_N = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pu_pkg::ctrl_t             ctrl,
  output pu_pkg::stat_t             stat,
  input  logic                      in_valid,
  input  logic [pu_pkg::N_W-1:0]    in_perm_length,
  input  logic [pu_pkg::RANK_W-1:0] in_rank,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [3:0]                out_element,
  output logic                      out_last,
  output logic                      out_error
);
  import pu_pkg::*;

  logic [N_W-1:0]    n_r, n_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [RANK_W-1:0] fact_r, fact_nxt;
  logic [N_W-1:0]    rem_r, rem_nxt;
  logic [N_W-1:0]    cand_r, cand_nxt;
  logic [MAX_N-1:0]  used_r, used_nxt;
  logic              ov_r, ov_nxt;
  logic [3:0]        el_r, el_nxt;
  logic              last_r, last_nxt;
  logic              err_r, err_nxt;
  logic              free;

  function automatic logic [N_W-1:0] next_free(input logic [MAX_N-1:0] mask,
                                               input logic [N_W-1:0] from);
    logic [N_W-1:0] v;
    v = '0;
    for (int i = MAX_N - 1; i >= 0; i--) begin
      if (!mask[i] && (N_W'(i + 1) > from)) begin
        v = N_W'(i + 1);
      end
    end
    return v;
  endfunction

  assign free = !ov_r || out_ready;

  assign stat.in_valid = in_valid;
  assign stat.bad  = (n_r == '0) || (n_r > N_W'(MAX_N)) || (rank_r == '0) ||
                     (rank_r > fact_of(n_r));
  assign stat.ge   = rank_r >= fact_r;
  assign stat.last = rem_r == N_W'(1);
  assign stat.free = free;

  always_comb begin
    n_nxt    = n_r;
    rank_nxt = rank_r;
    fact_nxt = fact_r;
    rem_nxt  = rem_r;
    cand_nxt = cand_r;
    used_nxt = used_r;
    ov_nxt   = ov_r && !out_ready;
    el_nxt   = el_r;
    last_nxt = last_r;
    err_nxt  = err_r;
    unique case (ctrl.op)
      OP_IDLE: begin
        if (in_valid) begin
          n_nxt    = in_perm_length;
          rank_nxt = in_rank;
        end
      end
      OP_INIT: begin
        rank_nxt = rank_r - RANK_W'(1);
        fact_nxt = fact_of(n_r - N_W'(1));
        rem_nxt  = n_r;
        used_nxt = '0;
        cand_nxt = N_W'(1);
      end
      OP_DIV: begin
        if (stat.ge) begin
          rank_nxt = rank_r - fact_r;
          cand_nxt = next_free(used_r, cand_r);
        end
      end
      OP_EMIT: begin
        if (free) begin
          ov_nxt   = 1'b1;
          el_nxt   = cand_r;
          last_nxt = stat.last;
          err_nxt  = 1'b0;
          rem_nxt  = rem_r - N_W'(1);
          for (int i = 0; i < MAX_N; i++) begin
            if (cand_r == N_W'(i + 1)) begin
              used_nxt[i] = 1'b1;
            end
          end
        end
      end
      OP_NEXT: begin
        fact_nxt = fact_of(rem_r - N_W'(1));
        cand_nxt = next_free(used_r, '0);
      end
      OP_ERR: begin
        if (free) begin
          ov_nxt   = 1'b1;
          el_nxt   = 4'd0;
          last_nxt = 1'b1;
          err_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rank_r <= rank_nxt;
    fact_r <= fact_nxt;
    rem_r  <= rem_nxt;
    cand_r <= cand_nxt;
    used_r <= used_nxt;
    el_r   <= el_nxt;
    last_r <= last_nxt;
    err_r  <= err_nxt;
  end

  assign out_valid   = ov_r;
  assign out_element = el_r;
  assign out_last    = last_r;
  assign out_error   = err_r;

endmodule

// ===== hw/rtl/permutation_unrank.sv =====
// top level: lexicographic permutation unranking, microcoded
//
//   channel  dir  transfer payload
//   in_ch    in   perm_length[3:0], rank[28:0]
//   out_ch   out  element[3:0], last, error
//
// one item at a time; per element the rank digit is found by repeated
// subtraction of (r-1)!, one subtract per cycle, and the element is then
// emitted; an out-of-range request gives an error result instead
// synchronous active-low reset clears the step counter and result valid
// a stalled result holds the sequencer on its emit or error step
module permutation_unrank #(
  parameter int MAX_N = 9
) (
  input logic      clk,
  input logic      rst_n,
  pu_in_if.sink    in_ch,
  pu_out_if.source out_ch
);
  import pu_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  pu_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  pu_dp #(.MAX_N(MAX_N)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_valid       (in_ch.valid),
    .in_perm_length (in_ch.perm_length),
    .in_rank        (in_ch.rank),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_element    (out_ch.element),
    .out_last       (out_ch.last),
    .out_error      (out_ch.error)
  );

  assign in_ch.ready = ctrl.ready;

endmodule

// ===== hw/rtl/pu_chk.sv =====
// port checker for the permutation unranker, with its bind
module pu_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_element,
  input logic       out_last,
  input logic       out_error
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_element) &&
    $stable(out_last) && $stable(out_error))
    else $error("result changed while stalled");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && out_element == 4'd0)
    else $error("malformed error result");

  a_elem_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error |-> out_element != 4'd0)
    else $error("zero element on good result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind permutation_unrank pu_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_element (out_ch.element),
  .out_last    (out_ch.last),
  .out_error   (out_ch.error)
);

// ===== verif/permutation_unrank_tb.sv =====
// testbench: permutation unranking checked against a predictor of the expected elements
module permutation_unrank_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pu_pkg::*;

  localparam int MAX_N = 9;

  typedef struct {
    logic [N_W-1:0]    len;
    logic [RANK_W-1:0] rank;
    int                gap;
  } perm_req_t;

  typedef struct {
    logic [3:0] element;
    logic       last;
    logic       error;
  } perm_elem_t;

  logic clk;
  logic rst_n;

  pu_in_if  in_ch();
  pu_out_if out_ch();

  permutation_unrank #(.MAX_N(MAX_N)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  perm_req_t  rank_reqs[$];
  perm_elem_t due_elems[$];
  perm_req_t  next_req;

  int in_hold;
  int out_hold;
  bit in_calm;
  bit out_calm;
  int n_accepted;
  int n_bad_in;
  int n_results;
  int n_mismatch;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint unsigned factorial(input int unsigned n);
    longint unsigned f;
    f = 1;
    for (int unsigned i = 2; i <= n; i++) f *= i;
    return f;
  endfunction

  // expected elements of one request, lexicographic order via factorial digits
  function automatic void unrank_into_due(input logic [N_W-1:0] len,
                                          input logic [RANK_W-1:0] rank);
    logic [3:0]      pool[12];
    longint unsigned radix;
    longint unsigned rest;
    int unsigned     sel;
    perm_elem_t      e;
    if (len < 1 || len > MAX_N || rank == 0 || rank > factorial(len)) begin
      e.element = 4'd0;
      e.last    = 1'b1;
      e.error   = 1'b1;
      due_elems = {due_elems, e};
      n_bad_in++;
      return;
    end
    for (int i = 0; i < len; i++) pool[i] = 4'(i + 1);
    radix = factorial(len - 1);
    rest  = rank - 1;
    for (int unsigned r = len; r > 0; r--) begin
      sel = int'(rest / radix);
      if (sel >= r) sel = r - 1;
      rest = rest % radix;
      e.element = pool[sel];
      e.last    = (r == 1);
      e.error   = 1'b0;
      due_elems = {due_elems, e};
      for (int unsigned j = sel; j + 1 < r; j++) pool[j] = pool[j + 1];
      if (r > 1) radix = radix / (r - 1);
    end
  endfunction

  task automatic report_mismatch(input string what);
    n_mismatch++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic queue_request(input int unsigned len, input longint unsigned rank);
    perm_req_t r;
    r.len  = N_W'(len);
    r.rank = RANK_W'(rank);
    r.gap  = in_calm ? 0 : $urandom_range(0, 13);
    rank_reqs = {rank_reqs, r};
  endtask

  // driver: presents queued requests, may idle between transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.perm_length <= '0;
      in_ch.rank        <= '0;
      in_hold           <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        unrank_into_due(in_ch.perm_length, in_ch.rank);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_hold > 0) begin
          in_ch.valid <= 1'b0;
          in_hold     <= in_hold - 1;
        end else if (rank_reqs.size() != 0) begin
          next_req = rank_reqs.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.perm_length <= next_req.len;
          in_ch.rank        <= next_req.rank;
          in_hold           <= next_req.gap;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer, stalls the result channel
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (due_elems.size() == 0) begin
          report_mismatch($sformatf("unexpected result element %0d last %0d error %0d",
                                    out_ch.element, out_ch.last, out_ch.error));
        end else begin
          perm_elem_t e;
          e = due_elems.pop_front();
          if (out_ch.element !== e.element)
            report_mismatch($sformatf("element %0d, expected %0d", out_ch.element, e.element));
          if (out_ch.last !== e.last)
            report_mismatch($sformatf("last %0d, expected %0d", out_ch.last, e.last));
          if (out_ch.error !== e.error)
            report_mismatch($sformatf("error %0d, expected %0d", out_ch.error, e.error));
        end
        if (n_results % 50 == 0) out_calm = ($urandom_range(0, 2) == 0);
        stall = out_calm ? 0 : $urandom_range(0, 13);
        out_ch.ready <= (stall == 0);
        out_hold     <= stall;
      end else if (!out_ch.ready) begin
        if (out_hold <= 1) out_ch.ready <= 1'b1;
        out_hold <= out_hold - 1;
      end
    end
  end

  initial begin
    longint unsigned f;
    int unsigned     n;
    rst_n   = 1'b0;
    in_calm = 1'b0;

    // field extremes, edges of the valid range, lengths past the limit
    queue_request(0, 1);
    queue_request(15, (1 << RANK_W) - 1);
    queue_request(10, 1);
    queue_request(12, 479001600);
    queue_request(1, 1);
    queue_request(1, 0);
    queue_request(1, 2);
    queue_request(2, 1);
    queue_request(2, 2);
    queue_request(3, 3);
    queue_request(4, 24);
    queue_request(4, 25);
    queue_request(5, 0);
    queue_request(7, 2520);
    queue_request(8, 40320);
    queue_request(9, 1);
    queue_request(9, 362880);
    queue_request(9, 362881);
    queue_request(9, (1 << RANK_W) - 1);
    queue_request(9, 181440);
    queue_request(11, 7);
    queue_request(13, 1);
    queue_request(14, 0);

    for (int i = 0; i < 300; i++) begin
      if (i % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0: queue_request($urandom_range(0, 15), $urandom & ((1 << RANK_W) - 1));
        1: begin
          n = $urandom_range(1, MAX_N);
          queue_request(n, factorial(n) + $urandom_range(1, 1000));
        end
        2: queue_request($urandom_range(1, MAX_N), 0);
        3: begin
          n = $urandom_range(1, MAX_N);
          queue_request(n, ($urandom_range(0, 1) != 0) ? factorial(n) : 1);
        end
        default: begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, MAX_N) : $urandom_range(1, 6);
          f = factorial(n);
          queue_request(n, $urandom_range(1, int'(f)));
        end
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (rank_reqs.size() != 0 || in_ch.valid) @(posedge clk);
    while (due_elems.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d request transfers, %0d of them out of range, %0d results checked",
             n_accepted, n_bad_in, n_results);
    $display("%0d mismatches seen", n_mismatch);
    if (n_mismatch == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timed out with %0d results still due", due_elems.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
